FILE: sv/sef_pkg.sv
// ----------------------------------------------------------------------------
// sef_pkg
// shared constants, types and helpers for the scaled exponential-integral block
// ----------------------------------------------------------------------------
package sef_pkg;

  localparam int unsigned MAX_TERMS     = 100;
  localparam int unsigned FRACTION_BITS = 16;

  localparam int unsigned IFB        = 40;
  localparam int unsigned BASE_TERMS = 20;
  localparam int unsigned TERM_SCALE = 80;
  localparam int unsigned ASYM_LIMIT = 1250;
  localparam int unsigned C120       = 120;
  localparam int unsigned C24        = 24;
  localparam int unsigned C6         = 6;
  localparam int unsigned C2         = 2;
  localparam int unsigned C1         = 1;

  localparam int unsigned XW  = 32;
  localparam int unsigned KW  = $clog2(MAX_TERMS + 1);
  localparam int unsigned NW  = KW + IFB;
  localparam int unsigned DWA = 33 + IFB - FRACTION_BITS;
  localparam int unsigned DW  = (DWA > NW + 1) ? DWA : NW + 1;
  localparam int unsigned QW  = NW + 1;
  localparam int unsigned WW  = QW + IFB;
  localparam int unsigned YW  = 30;
  localparam int unsigned PW  = IFB + 5;
  localparam int unsigned CW  = $clog2(WW + 1);
  localparam int unsigned PIW = 2;

  typedef enum logic [0:0] {
    OP_DIV,
    OP_MUL
  } sef_op_e;

  typedef struct packed {
    logic    start;
    sef_op_e op;
    logic    frac;
  } sef_req_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_TERMS,
    ST_INNER,
    ST_OUTER,
    ST_LAST,
    ST_RECIP,
    ST_POLY,
    ST_DONE
  } sef_state_e;

  // polynomial constants, innermost first
  function automatic logic [PW-1:0] poly_coef(input logic [PIW-1:0] idx);
    logic [PW-1:0] c;
    case (idx)
      2'd0:    c = PW'(C6) << IFB;
      2'd1:    c = PW'(C2) << IFB;
      default: c = PW'(C1) << IFB;
    endcase
    return c;
  endfunction

endpackage

FILE: sv/sef_unit.sv
// ----------------------------------------------------------------------------
// sef_unit
// shared bit-serial unit: restoring divider and shift-add multiplier
// ----------------------------------------------------------------------------
module sef_unit (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  sef_pkg::sef_req_t         req_i,
  input  logic [sef_pkg::NW-1:0]    num_i,
  input  logic [sef_pkg::DW-1:0]    den_i,
  output logic                      done_o,
  output logic [sef_pkg::QW-1:0]    result_o
);

  logic [sef_pkg::CW-1:0] cnt_q;
  logic                   done_q;
  sef_pkg::sef_op_e       op_q;
  logic [sef_pkg::NW-1:0] n_q;
  logic [sef_pkg::DW-1:0] d_q;
  logic [sef_pkg::DW-1:0] r_q, r_d;
  logic [sef_pkg::WW-1:0] w_q, w_d;
  logic [sef_pkg::DW:0]   rs;
  logic                   ge;

  always_comb begin
    rs  = {r_q, n_q[sef_pkg::NW-1]};
    ge  = (rs >= {1'b0, d_q});
    r_d = r_q;
    w_d = w_q;
    case (op_q)
      sef_pkg::OP_DIV: begin
        r_d = ge ? sef_pkg::DW'(rs - {1'b0, d_q}) : rs[sef_pkg::DW-1:0];
        w_d = {w_q[sef_pkg::WW-2:0], ge};
      end
      sef_pkg::OP_MUL: begin
        w_d = {w_q[sef_pkg::WW-2:0], 1'b0} +
              (d_q[sef_pkg::YW-1] ? sef_pkg::WW'(n_q) : '0);
      end
      default: begin
        w_d = w_q;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      done_q <= 1'b0;
    end else begin
      done_q <= (cnt_q == sef_pkg::CW'(1));
      if (req_i.start) begin
        if (req_i.op == sef_pkg::OP_MUL) begin
          cnt_q <= sef_pkg::CW'(sef_pkg::YW);
        end else if (req_i.frac) begin
          cnt_q <= sef_pkg::CW'(sef_pkg::NW + sef_pkg::IFB);
        end else begin
          cnt_q <= sef_pkg::CW'(sef_pkg::NW);
        end
      end else if (cnt_q != '0) begin
        cnt_q <= cnt_q - sef_pkg::CW'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.start) begin
      op_q <= req_i.op;
      n_q  <= num_i;
      d_q  <= den_i;
      r_q  <= '0;
      w_q  <= '0;
    end else if (cnt_q != '0) begin
      r_q <= r_d;
      w_q <= w_d;
      if (op_q == sef_pkg::OP_MUL) begin
        d_q <= d_q << 1;
      end else begin
        n_q <= n_q << 1;
      end
    end
  end

  assign done_o   = done_q;
  assign result_o = (op_q == sef_pkg::OP_MUL) ?
                    w_q[sef_pkg::QW+sef_pkg::IFB-1:sef_pkg::IFB] :
                    w_q[sef_pkg::QW-1:0];

endmodule

FILE: sv/scaled_expint_factor.sv
// ----------------------------------------------------------------------------
// scaled_expint_factor
// x * exp(x) * E1(x) for an unsigned Q16.16 argument, result in Q1.31
// ----------------------------------------------------------------------------
// Input channel s_axis carries the argument x in tdata. Output channel m_axis
// carries F(x) in tdata (Q1.31, 1.0 = 2^31) and a status flag in tuser that
// is set, with zero data, for arguments in (0,1], which are not evaluated.
// One result transaction follows every input transaction, in order.
// All arithmetic runs on one bit-serial divide/multiply unit under a small
// sequencer, one bit per cycle. For 1 < x <= 1250 the continued fraction
// uses m = 20 + floor(80/x) terms, capped at 100, each term two divides.
// s_axis_tready is high only while the sequencer is idle. A finished result
// sits in the output register while the next argument is taken; the
// sequencer waits at its end while the receiver stalls. Reset returns the
// sequencer to idle and drops m_axis_tvalid.
// ----------------------------------------------------------------------------
module scaled_expint_factor (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [31:0] s_axis_tdata,   // x_value
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [31:0] m_axis_tdata,   // factor
  output logic        m_axis_tuser    // status
);

  sef_pkg::sef_state_e      state_q, state_d;
  logic                     go_q, go_d;
  logic [sef_pkg::KW-1:0]   k_q, k_d;
  logic [sef_pkg::NW-1:0]   t_q, t_d;
  logic [sef_pkg::NW-1:0]   inner_q, inner_d;
  logic [sef_pkg::YW-1:0]   y_q, y_d;
  logic [sef_pkg::PW-1:0]   p_q, p_d;
  logic [sef_pkg::PW-1:0]   v_q, v_d;
  logic [sef_pkg::PIW-1:0]  pidx_q, pidx_d;
  logic [sef_pkg::XW-1:0]   xv_q, xv_d;
  logic [sef_pkg::DW-1:0]   xq_q, xq_d;
  logic                     stat_q, stat_d;
  logic                     mvalid_q;
  logic [31:0]              mdata_q;
  logic                     muser_q;
  logic                     load_out;

  sef_pkg::sef_req_t        req;
  logic [sef_pkg::NW-1:0]   num;
  logic [sef_pkg::DW-1:0]   den;
  logic                     done;
  logic [sef_pkg::QW-1:0]   res;
  logic [sef_pkg::QW-1:0]   mterm;
  logic [sef_pkg::PW-1:0]   pnext;
  logic [sef_pkg::PW:0]     vrnd;
  logic [sef_pkg::PW-9:0]   fr;
  logic [31:0]              fsat;

  sef_unit u_unit (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .req_i    (req),
    .num_i    (num),
    .den_i    (den),
    .done_o   (done),
    .result_o (res)
  );

  assign s_axis_tready = (state_q == sef_pkg::ST_IDLE);

  always_comb begin
    vrnd = (sef_pkg::PW+1)'(v_q) + ((sef_pkg::PW+1)'(1) << 8);
    fr   = vrnd[sef_pkg::PW:9];
    fsat = (fr > ((sef_pkg::PW-8)'(1) << 31)) ? (32'd1 << 31) : fr[31:0];
    mterm = res + sef_pkg::QW'(sef_pkg::BASE_TERMS);
    pnext = sef_pkg::poly_coef(pidx_q) - sef_pkg::PW'(res);
  end

  always_comb begin
    state_d  = state_q;
    go_d     = go_q;
    k_d      = k_q;
    t_d      = t_q;
    inner_d  = inner_q;
    y_d      = y_q;
    p_d      = p_q;
    v_d      = v_q;
    pidx_d   = pidx_q;
    xv_d     = xv_q;
    xq_d     = xq_q;
    stat_d   = stat_q;
    load_out = 1'b0;
    req      = '{start: 1'b0, op: sef_pkg::OP_DIV, frac: 1'b1};
    num      = sef_pkg::NW'(1) << sef_pkg::IFB;
    den      = (sef_pkg::DW'(1) << sef_pkg::IFB) + sef_pkg::DW'(t_q);

    case (state_q)
      sef_pkg::ST_TERMS: begin
        req.frac = 1'b0;
        num = sef_pkg::NW'(sef_pkg::TERM_SCALE) << sef_pkg::FRACTION_BITS;
        den = sef_pkg::DW'(xv_q);
      end
      sef_pkg::ST_INNER: begin
        num = sef_pkg::NW'(k_q) << sef_pkg::IFB;
      end
      sef_pkg::ST_OUTER: begin
        num = sef_pkg::NW'(k_q) << sef_pkg::IFB;
        den = xq_q + sef_pkg::DW'(inner_q);
      end
      sef_pkg::ST_RECIP: begin
        den = xq_q;
      end
      sef_pkg::ST_POLY: begin
        req.op = sef_pkg::OP_MUL;
        num = sef_pkg::NW'(p_q);
        den = sef_pkg::DW'(y_q);
      end
      default: begin
        req.frac = 1'b1;
      end
    endcase

    case (state_q)
      sef_pkg::ST_IDLE: begin
        if (s_axis_tvalid) begin
          xv_d   = s_axis_tdata;
          xq_d   = sef_pkg::DW'(s_axis_tdata) << (sef_pkg::IFB - sef_pkg::FRACTION_BITS);
          v_d    = '0;
          stat_d = 1'b0;
          go_d   = 1'b0;
          if (s_axis_tdata == '0) begin
            state_d = sef_pkg::ST_DONE;
          end else if (64'(s_axis_tdata) <= (64'd1 << sef_pkg::FRACTION_BITS)) begin
            stat_d  = 1'b1;
            state_d = sef_pkg::ST_DONE;
          end else if (64'(s_axis_tdata) <=
                       (64'(sef_pkg::ASYM_LIMIT) << sef_pkg::FRACTION_BITS)) begin
            state_d = sef_pkg::ST_TERMS;
          end else begin
            state_d = sef_pkg::ST_RECIP;
          end
        end
      end
      sef_pkg::ST_DONE: begin
        if (!mvalid_q || m_axis_tready) begin
          load_out = 1'b1;
          state_d  = sef_pkg::ST_IDLE;
        end
      end
      default: begin
        if (!go_q) begin
          req.start = 1'b1;
          go_d      = 1'b1;
        end else if (done) begin
          go_d = 1'b0;
          case (state_q)
            sef_pkg::ST_TERMS: begin
              k_d = (mterm > sef_pkg::QW'(sef_pkg::MAX_TERMS)) ?
                    sef_pkg::KW'(sef_pkg::MAX_TERMS) : mterm[sef_pkg::KW-1:0];
              t_d = '0;
              state_d = sef_pkg::ST_INNER;
            end
            sef_pkg::ST_INNER: begin
              inner_d = res[sef_pkg::NW-1:0];
              state_d = sef_pkg::ST_OUTER;
            end
            sef_pkg::ST_OUTER: begin
              t_d = res[sef_pkg::NW-1:0];
              k_d = k_q - sef_pkg::KW'(1);
              state_d = (k_q == sef_pkg::KW'(1)) ? sef_pkg::ST_LAST : sef_pkg::ST_INNER;
            end
            sef_pkg::ST_LAST: begin
              v_d = sef_pkg::PW'(res);
              state_d = sef_pkg::ST_DONE;
            end
            sef_pkg::ST_RECIP: begin
              y_d = res[sef_pkg::YW-1:0];
              p_d = (sef_pkg::PW'(sef_pkg::C24) << sef_pkg::IFB) -
                    ((sef_pkg::PW'(res[sef_pkg::YW-1:0]) << 7) -
                     (sef_pkg::PW'(res[sef_pkg::YW-1:0]) << 3));
              pidx_d = '0;
              state_d = sef_pkg::ST_POLY;
            end
            sef_pkg::ST_POLY: begin
              p_d = pnext;
              if (pidx_q == sef_pkg::PIW'(3)) begin
                v_d = pnext;
                state_d = sef_pkg::ST_DONE;
              end else begin
                pidx_d = pidx_q + sef_pkg::PIW'(1);
              end
            end
            default: begin
              state_d = sef_pkg::ST_IDLE;
            end
          endcase
        end
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= sef_pkg::ST_IDLE;
      go_q     <= 1'b0;
      mvalid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      go_q    <= go_d;
      if (load_out) begin
        mvalid_q <= 1'b1;
      end else if (m_axis_tready) begin
        mvalid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    k_q     <= k_d;
    t_q     <= t_d;
    inner_q <= inner_d;
    y_q     <= y_d;
    p_q     <= p_d;
    v_q     <= v_d;
    pidx_q  <= pidx_d;
    xv_q    <= xv_d;
    xq_q    <= xq_d;
    stat_q  <= stat_d;
    if (load_out) begin
      mdata_q <= stat_q ? 32'd0 : fsat;
      muser_q <= stat_q;
    end
  end

  assign m_axis_tvalid = mvalid_q;
  assign m_axis_tdata  = mdata_q;
  assign m_axis_tuser  = muser_q;

  // result never above one
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> (m_axis_tdata <= (32'd1 << 31)))
    else $error("factor above one");

  // unhandled argument carries zero data
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && m_axis_tuser) |-> (m_axis_tdata == 32'd0))
    else $error("flagged result with data");

  // busy after a transaction is taken
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_axis_tvalid && s_axis_tready) |=> !s_axis_tready)
    else $error("ready right after accept");

  // term counter within its cap while iterating
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == sef_pkg::ST_INNER || state_q == sef_pkg::ST_OUTER) |->
      (k_q <= sef_pkg::KW'(sef_pkg::MAX_TERMS) && k_q != '0))
    else $error("term counter out of range");

endmodule
